>>> hw/rtl/aep_pkg.sv
`timescale 1ns / 1ps
package aep_pkg;

  // default parameter values
  localparam int SUB_SAMPLES_DEF = 32;
  localparam int MAX_WIDTH_DEF   = 4096;
  localparam int MAX_HEIGHT_DEF  = 4096;

  // field widths
  localparam int PIX_W   = 12;
  localparam int CTR_W   = 21;
  localparam int INV_W   = 24;
  localparam int D_W     = 23;   // signed q.8 offset
  localparam int R2_W    = 61;   // q.56 radius squared
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [R2_W-1:0] ONE_Q56 = R2_W'(1) << 56;

  // queue depths
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_AXIS_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_AXIS_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOME_MODE  = 3'd4;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] intensity;
    logic       was_edge;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_ZERO = 2'd0,
    KIND_FILL = 2'd1,
    KIND_EDGE = 2'd2
  } kind_t;

  // classified pixel handed from front to back
  typedef struct packed {
    kind_t                kind;
    logic [7:0]           value;
    logic signed [D_W-1:0] dx0;
    logic signed [D_W-1:0] dy0;
  } mid_item_t;

  // ellipse setup shared by both radius units
  typedef struct packed {
    logic [INV_W-1:0] inv_x;
    logic [INV_W-1:0] inv_y;
    logic             dome;
  } shape_t;

endpackage

>>> hw/rtl/aep_radius.sv
`timescale 1ns / 1ps
module aep_radius
  import aep_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [D_W-1:0] dx,
  input  logic signed [D_W-1:0] dy,
  input  shape_t                shape,
  output logic                  out_valid,
  output logic [R2_W-1:0]       r2
);

  localparam int P_W = D_W + INV_W + 2;
  localparam logic [P_W-1:0] U_LIMIT = P_W'(1) << 29;

  logic signed [P_W-1:0] px, py;
  logic [29:0] ax, ay;
  logic [59:0] sx, sy;
  logic [P_W-1:0] abs_x, abs_y;
  logic [2:0] vld;

  always_comb begin
    abs_x = px[P_W-1] ? P_W'(-px) : P_W'(px);
    abs_y = py[P_W-1] ? P_W'(-py) : P_W'(py);
    ax = (abs_x > U_LIMIT) ? 30'(U_LIMIT) : abs_x[29:0];
    ay = (abs_y > U_LIMIT) ? 30'(U_LIMIT) : abs_y[29:0];
  end

  // stage 1 scale, stage 2 saturate and square, stage 3 sum
  always_ff @(posedge clk) begin
    px <= P_W'(dx * $signed({1'b0, shape.inv_x}));
    py <= P_W'(dy * $signed({1'b0, shape.inv_y}));
    sx <= ax * ax;
    sy <= ay * ay;
    r2 <= R2_W'(sx) + R2_W'(sy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], in_valid};
    end
  end

  assign out_valid = vld[2];

endmodule

>>> hw/rtl/aep_queue.sv
`timescale 1ns / 1ps
module aep_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/aep_front.sv
`timescale 1ns / 1ps
module aep_front
  import aep_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  in_item_t              pixel,
  output logic                  full,
  input  logic signed [CTR_W-1:0] center_x,
  input  logic signed [CTR_W-1:0] center_y,
  input  shape_t                shape,
  output logic                  mid_push,
  output mid_item_t             mid_item,
  input  logic                  mid_full
);

  localparam logic [2:0] CORNERS = 3'd4;
  localparam logic [2:0] POINTS  = 3'd5;

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_ISSUE = 4'b0010,
    F_WAIT  = 4'b0100,
    F_PUSH  = 4'b1000
  } fstate_t;

  fstate_t state;
  logic signed [D_W-1:0] dx0, dy0, qx, qy;
  logic [2:0] issue_idx, ret_idx;
  logic all_out, all_in;
  logic [7:0] dome_val;
  logic r_valid;
  logic [R2_W-1:0] r2;
  logic [R2_W-1:0] c_diff;
  logic [32:0] cw;
  logic [40:0] cw255;
  logic in_range;
  logic signed [D_W-1:0] acc_dx, acc_dy;

  assign full = (state != F_IDLE);

  assign in_range = ({1'b0, pixel.pixel_x} < 13'(MAX_WIDTH))
                 && ({1'b0, pixel.pixel_y} < 13'(MAX_HEIGHT));
  assign acc_dx = $signed({3'b0, pixel.pixel_x, 8'b0})
                - $signed({{(D_W-CTR_W){center_x[CTR_W-1]}}, center_x});
  assign acc_dy = $signed({3'b0, pixel.pixel_y, 8'b0})
                - $signed({{(D_W-CTR_W){center_y[CTR_W-1]}}, center_y});

  // corners, then the pixel centre
  always_comb begin
    qx = dx0;
    qy = dy0;
    case (issue_idx)
      3'd1: qx = dx0 + D_W'(256);
      3'd2: qy = dy0 + D_W'(256);
      3'd3: begin
        qx = dx0 + D_W'(256);
        qy = dy0 + D_W'(256);
      end
      3'd4: begin
        qx = dx0 + D_W'(128);
        qy = dy0 + D_W'(128);
      end
      default: ;
    endcase
  end

  aep_radius u_radius (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (state == F_ISSUE),
    .dx        (qx),
    .dy        (qy),
    .shape     (shape),
    .out_valid (r_valid),
    .r2        (r2)
  );

  // dome height at the centre
  always_comb begin
    c_diff = ONE_Q56 - r2;
    cw     = (r2 < ONE_Q56) ? c_diff[56:24] : '0;
    cw255  = {cw, 8'b0} - 41'(cw);
  end

  always_comb begin
    mid_item.dx0 = dx0;
    mid_item.dy0 = dy0;
    if (all_out) begin
      mid_item.kind  = KIND_ZERO;
      mid_item.value = 8'd0;
    end else if (all_in) begin
      mid_item.kind  = KIND_FILL;
      mid_item.value = shape.dome ? dome_val : 8'd255;
    end else begin
      mid_item.kind  = KIND_EDGE;
      mid_item.value = 8'd0;
    end
  end

  assign mid_push = (state == F_PUSH) && !mid_full;

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      dx0 <= acc_dx;
      dy0 <= acc_dy;
    end
    if (r_valid && ret_idx == CORNERS) begin
      dome_val <= cw255[39:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      issue_idx <= '0;
      ret_idx   <= '0;
      all_out   <= 1'b0;
      all_in    <= 1'b0;
    end else begin
      if (r_valid) begin
        ret_idx <= ret_idx + 1'b1;
        if (ret_idx < CORNERS) begin
          all_out <= all_out && (r2 > ONE_Q56);
          all_in  <= all_in && (r2 < ONE_Q56);
        end
      end
      case (state)
        F_IDLE: begin
          if (push) begin
            issue_idx <= '0;
            ret_idx   <= '0;
            all_out   <= 1'b1;
            all_in    <= in_range;
            state     <= in_range ? F_ISSUE : F_PUSH;
          end
        end
        F_ISSUE: begin
          issue_idx <= issue_idx + 1'b1;
          if (issue_idx == POINTS - 3'd1) begin
            state <= F_WAIT;
          end
        end
        F_WAIT: begin
          if (ret_idx == POINTS) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!mid_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/aep_back.sv
`timescale 1ns / 1ps
module aep_back
  import aep_pkg::*;
#(
  parameter int SUB_SAMPLES = SUB_SAMPLES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  mid_item_t mid_item,
  input  logic      mid_empty,
  output logic      mid_pop,
  input  shape_t    shape,
  output logic      out_push,
  output out_item_t out_item,
  input  logic      out_full
);

  localparam int CELLS   = SUB_SAMPLES * SUB_SAMPLES;
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int WSUM_W  = CNT_W + 33;
  localparam int PROD_W  = WSUM_W + 8;
  localparam int NUM_W   = CNT_W + 8;
  localparam int CELL_LG = $clog2(CELLS);
  localparam int SHIFT   = NUM_W + CELL_LG;
  localparam int RCP_W   = NUM_W + 2;
  // ceil(2^SHIFT / CELLS), exact floor division for numerators below 2^NUM_W
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << SHIFT) + 64'(CELLS) - 64'd1) / 64'(CELLS));
  localparam int IDX_W  = $clog2(SUB_SAMPLES);
  localparam int REM_W  = $clog2(2 * SUB_SAMPLES);
  localparam int STEP_Q = 256 / SUB_SAMPLES;
  localparam int STEP_R = 256 % SUB_SAMPLES;

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_SWEEP = 5'b00010,
    B_DRAIN = 5'b00100,
    B_DIV   = 5'b01000,
    B_PUSH  = 5'b10000
  } bstate_t;

  typedef struct packed {
    logic [8:0]       q;
    logic [REM_W-1:0] r;
  } offs_t;

  bstate_t state;
  logic signed [D_W-1:0] dx0, dy0, sx, sy;
  logic [IDX_W-1:0] ki, li;
  offs_t xo, yo;
  logic [CNT_W-1:0] count, recv;
  logic [WSUM_W-1:0] wsum;
  logic [PROD_W-1:0] wprod;
  logic [NUM_W-1:0] num;
  logic [NUM_W+RCP_W-1:0] qprod;
  logic r_valid;
  logic [R2_W-1:0] r2, s_diff;

  // next sample offset floor(k*256/SUB_SAMPLES) by running remainder
  function automatic offs_t step_offs(offs_t o);
    offs_t n;
    n.q = o.q + 9'(STEP_Q);
    n.r = o.r + REM_W'(STEP_R);
    if (n.r >= REM_W'(SUB_SAMPLES)) begin
      n.r = n.r - REM_W'(SUB_SAMPLES);
      n.q = n.q + 9'd1;
    end
    return n;
  endfunction

  assign sx = dx0 + $signed({{(D_W-9){1'b0}}, xo.q});
  assign sy = dy0 + $signed({{(D_W-9){1'b0}}, yo.q});

  aep_radius u_radius (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (state == B_SWEEP),
    .dx        (sx),
    .dy        (sy),
    .shape     (shape),
    .out_valid (r_valid),
    .r2        (r2)
  );

  assign s_diff   = ONE_Q56 - r2;
  assign wprod    = {wsum, 8'b0} - PROD_W'(wsum);
  assign qprod    = num * RECIP;
  assign mid_pop  = (state == B_IDLE) && !mid_empty;
  assign out_push = (state == B_PUSH) && !out_full;

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      dx0 <= mid_item.dx0;
      dy0 <= mid_item.dy0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      ki       <= '0;
      li       <= '0;
      xo       <= '0;
      yo       <= '0;
      count    <= '0;
      recv     <= '0;
      wsum     <= '0;
      num      <= '0;
      out_item <= '0;
    end else begin
      if (r_valid) begin
        recv <= recv + 1'b1;
        if (r2 < ONE_Q56) begin
          count <= count + 1'b1;
          wsum  <= wsum + WSUM_W'(s_diff[56:24]);
        end
      end
      case (state)
        B_IDLE: begin
          if (!mid_empty) begin
            ki    <= '0;
            li    <= '0;
            xo    <= '0;
            yo    <= '0;
            count <= '0;
            recv  <= '0;
            wsum  <= '0;
            out_item.intensity <= mid_item.value;
            out_item.was_edge  <= 1'b0;
            state <= (mid_item.kind == KIND_EDGE) ? B_SWEEP : B_PUSH;
          end
        end
        B_SWEEP: begin
          if (li == IDX_W'(SUB_SAMPLES - 1)) begin
            li <= '0;
            yo <= '0;
            ki <= ki + 1'b1;
            xo <= step_offs(xo);
            if (ki == IDX_W'(SUB_SAMPLES - 1)) begin
              state <= B_DRAIN;
            end
          end else begin
            li <= li + 1'b1;
            yo <= step_offs(yo);
          end
        end
        B_DRAIN: begin
          if (recv == CNT_W'(CELLS)) begin
            // dome drops the 2^32 weight scale first, then both divide by CELLS
            if (shape.dome) begin
              num <= wprod[32 +: NUM_W];
            end else begin
              num <= {count, 8'b0} - NUM_W'(count);
            end
            state <= B_DIV;
          end
        end
        B_DIV: begin
          // divide by CELLS as a reciprocal multiply
          out_item.intensity <= qprod[SHIFT +: 8];
          out_item.was_edge  <= 1'b1;
          state <= B_PUSH;
        end
        B_PUSH: begin
          if (!out_full) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/antialiased_ellipse_pixel_top.sv
`timescale 1ns / 1ps
// anti-aliased ellipse pixel evaluator. push a pixel coordinate, pop one 8-bit
// intensity per pixel in order. the front unit tests the four pixel corners and
// the pixel centre through its own radius pipeline and takes a new pixel only
// after handing the last one on; it classifies the pixel as outside, inside or
// edge. every pixel then goes through a two-entry queue to the back unit. fully
// inside or outside pixels skip the sampling in the back. for edge pixels the back
// streams SUB_SAMPLES^2 subsamples one per cycle through a second radius
// pipeline, waits in a drain state for the last one, then scales the sum with a
// reciprocal multiply; the cost of an edge pixel is set by that single sample
// pipeline. the front keeps classifying the next pixels while the back is busy,
// until the two-entry queue fills. write registers only while no pixel is in
// flight.
module antialiased_ellipse_pixel_top
  import aep_pkg::*;
#(
  parameter int SUB_SAMPLES = SUB_SAMPLES_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // request side
  input  logic                 push,
  input  in_item_t             pixel,
  output logic                 full,
  // result side
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            result,
  // configuration writes
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int MID_W = $bits(mid_item_t);
  localparam int OUT_W = $bits(out_item_t);

  // configuration registers
  logic signed [CTR_W-1:0] center_x, center_y;
  shape_t shape;

  // front to back queue
  logic       mid_push, mid_full, mid_pop, mid_empty;
  mid_item_t  mid_wr, mid_rd;
  logic [MID_W-1:0] mid_rd_bits;

  // back to result queue
  logic       out_push, out_full;
  out_item_t  out_wr;
  logic [OUT_W-1:0] out_rd_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      shape.inv_x <= INV_W'(1048576);
      shape.inv_y <= INV_W'(1048576);
      shape.dome  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTER_X:   center_x    <= cfg_data[CTR_W-1:0];
        REG_CENTER_Y:   center_y    <= cfg_data[CTR_W-1:0];
        REG_INV_AXIS_X: shape.inv_x <= cfg_data[INV_W-1:0];
        REG_INV_AXIS_Y: shape.inv_y <= cfg_data[INV_W-1:0];
        REG_DOME_MODE:  shape.dome  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // corner tests and fast-path values
  aep_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pixel    (pixel),
    .full     (full),
    .center_x (center_x),
    .center_y (center_y),
    .shape    (shape),
    .mid_push (mid_push),
    .mid_item (mid_wr),
    .mid_full (mid_full)
  );

  aep_queue #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wr),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rd_bits),
    .empty (mid_empty)
  );

  assign mid_rd = mid_item_t'(mid_rd_bits);

  // subgrid sampling and final scaling
  aep_back #(
    .SUB_SAMPLES (SUB_SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_item  (mid_rd),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .shape     (shape),
    .out_push  (out_push),
    .out_item  (out_wr),
    .out_full  (out_full)
  );

  // result skid queue, lets the back start the next pixel while one waits
  aep_queue #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wr),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rd_bits),
    .empty (empty)
  );

  assign result = out_item_t'(out_rd_bits);

  // the front never hands over a pixel the middle queue cannot hold
  a_mid_no_overflow: assert property (@(posedge clk) disable iff (rst)
    mid_push |-> !mid_full)
    else $error("middle queue overrun");

  // the back never drops a result into a full result queue
  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result queue overrun");

  // a fast-path result from the back never claims the sampling path
  a_fast_not_edge: assert property (@(posedge clk) disable iff (rst)
    (mid_pop && mid_rd.kind != KIND_EDGE) |=> !out_wr.was_edge)
    else $error("fast path marked as edge");

endmodule
